/* hw/rtl/angt_pkg.sv */
// ----------------------------------------------------------------------------
// Angle tracker package
// Shared types, fixed-point constants and register indexes of the
// multi-turn angle tracker.
// ----------------------------------------------------------------------------
package angt_pkg;

  localparam int FRACTION_BITS = 16;

  localparam logic [63:0] PI_X40     = 64'h0000_0324_3F6A_8886;
  localparam logic [63:0] TWO_PI_X40 = 64'h0000_0648_7ED5_110B;

  localparam logic [63:0] PI_Q =
    (PI_X40 + (64'd1 << (39 - FRACTION_BITS))) >> (40 - FRACTION_BITS);
  localparam logic [63:0] TWO_PI_Q =
    (TWO_PI_X40 + (64'd1 << (39 - FRACTION_BITS))) >> (40 - FRACTION_BITS);
  localparam logic [63:0] LIMIT_Q =
    (64'd7 * PI_X40 + (64'd1 << (41 - FRACTION_BITS))) >> (42 - FRACTION_BITS);

  localparam logic [31:0] UNITY_Q16 = 32'd65536;

  typedef enum logic [1:0] {
    REG_INVERSE_GEAR_RATIO = 2'd0,
    REG_TORQUE_GAIN        = 2'd1,
    REG_OUTPUT_INVERT      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               motor_present;
    logic               online;
    logic               feedback_ok;
    logic        [18:0] rotor_angle;
    logic signed [27:0] rotor_velocity;
    logic signed [23:0] iq_current;
    logic signed [8:0]  temperature;
  } sample_t;

  typedef struct packed {
    logic              online_out;
    logic              resync;
    logic signed [8:0] temperature_out;
  } track_flags_t;

endpackage

/* hw/rtl/angt_tracker.sv */
// ----------------------------------------------------------------------------
// Angle tracker core
// Wraps the angle step, checks it against the step limit and updates the
// saturating multi-turn accumulator, one sample per cycle while take is high.
// ----------------------------------------------------------------------------
module angt_tracker #(
  parameter int ACCUMULATOR_WIDTH = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic                                take,
  input  angt_pkg::sample_t                   sample,
  output angt_pkg::track_flags_t              flags,
  output logic signed [ACCUMULATOR_WIDTH-1:0] position,
  output logic signed [27:0]                  velocity,
  output logic signed [23:0]                  current
);
  import angt_pkg::*;

  localparam int AW = ACCUMULATOR_WIDTH;
  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW - 1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW - 1){1'b0}}};
  localparam logic signed [20:0] PI_D     = 21'(PI_Q);
  localparam logic signed [20:0] TWO_PI_D = 21'(TWO_PI_Q);

  logic                 tracker_valid, tracker_valid_next;
  logic        [18:0]   last_angle, last_angle_next;
  logic signed [AW-1:0] accumulated_angle, accumulated_angle_next;
  logic                 was_online, was_online_next;

  logic                 active;
  logic signed [20:0]   diff;
  logic signed [20:0]   step;
  logic        [20:0]   abs_step;
  logic        [27:0]   abs_vel;
  logic        [28:0]   step_limit;
  logic signed [AW:0]   sum;
  logic signed [AW-1:0] sum_sat;
  logic                 resync;

  assign active = sample.motor_present & sample.online & sample.feedback_ok;
  assign diff   = $signed({2'b00, sample.rotor_angle}) - $signed({2'b00, last_angle});

  // A 19-bit angle step never needs more than one correction by a full turn.
  always_comb begin
    if (diff > PI_D) begin
      step = diff - TWO_PI_D;
    end else if (diff < -PI_D) begin
      step = diff + TWO_PI_D;
    end else begin
      step = diff;
    end
  end

  assign abs_step   = step[20] ? 21'(-step) : 21'(step);
  assign abs_vel    = sample.rotor_velocity[27] ? 28'(-sample.rotor_velocity)
                                                : 28'(sample.rotor_velocity);
  assign step_limit = (abs_vel != 28'd0) ? {1'b0, abs_vel} + 29'(PI_Q) : 29'(LIMIT_Q);

  assign sum = (AW + 1)'(accumulated_angle) + (AW + 1)'(step);

  always_comb begin
    if (sum[AW] != sum[AW-1]) begin
      sum_sat = sum[AW] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[AW-1:0];
    end
  end

  always_comb begin
    tracker_valid_next     = tracker_valid;
    last_angle_next        = last_angle;
    accumulated_angle_next = accumulated_angle;
    resync                 = 1'b0;
    if (!active) begin
      tracker_valid_next     = 1'b0;
      last_angle_next        = '0;
      accumulated_angle_next = '0;
      was_online_next        = sample.motor_present & sample.online;
    end else begin
      was_online_next = 1'b1;
      if (!was_online || !tracker_valid || (29'(abs_step) > step_limit)) begin
        tracker_valid_next     = 1'b1;
        last_angle_next        = sample.rotor_angle;
        accumulated_angle_next = AW'(sample.rotor_angle);
        resync                 = was_online & tracker_valid;
      end else begin
        last_angle_next        = sample.rotor_angle;
        accumulated_angle_next = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracker_valid     <= 1'b0;
      last_angle        <= '0;
      accumulated_angle <= '0;
      was_online        <= 1'b0;
    end else if (take) begin
      tracker_valid     <= tracker_valid_next;
      last_angle        <= last_angle_next;
      accumulated_angle <= accumulated_angle_next;
      was_online        <= was_online_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags.online_out      <= sample.motor_present & sample.online;
      flags.resync          <= resync;
      flags.temperature_out <= sample.motor_present ? sample.temperature : 9'sd0;
      position              <= active ? accumulated_angle_next : '0;
      velocity              <= active ? sample.rotor_velocity : 28'sd0;
      current               <= active ? sample.iq_current : 24'sd0;
    end
  end

endmodule

/* hw/rtl/angt_scale.sv */
// ----------------------------------------------------------------------------
// Gain scaler
// Multiplies a signed value by an unsigned Q16.16 gain in two stages,
// rounds half away from zero, saturates and optionally negates.
// ----------------------------------------------------------------------------
module angt_scale #(
  parameter int IN_W  = 48,
  parameter int OUT_W = 48
) (
  input  logic                    clk,
  input  logic                    en_mul,
  input  logic                    en_out,
  input  logic signed [IN_W-1:0]  value,
  input  logic        [31:0]      gain,
  input  logic                    negate,
  output logic signed [OUT_W-1:0] result
);

  localparam logic [63:0] LIMIT = 64'd1 << (OUT_W - 1);

  logic [IN_W-1:0] mag;
  logic [63:0]     mag_wide;
  logic [63:0]     prod_hi, prod_lo;
  logic            negative;
  logic [63:0]     rounded, clipped, signed_res;

  assign mag      = value[IN_W-1] ? IN_W'(-value) : IN_W'(value);
  assign mag_wide = 64'(mag);

  // The upper and lower halves of the magnitude each take one 32 by 32 product.
  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_hi  <= 64'(mag_wide[63:32]) * 64'(gain);
      prod_lo  <= 64'(mag_wide[31:0]) * 64'(gain) + 64'd32768;
      negative <= value[IN_W-1] ^ negate;
    end
  end

  assign rounded = (prod_hi >= LIMIT) ? LIMIT
                                      : {prod_hi[47:0], 16'd0} + {16'd0, prod_lo[63:16]};
  assign clipped = (rounded > LIMIT) ? LIMIT : rounded;

  always_comb begin
    if (negative) begin
      signed_res = -clipped;
    end else if (clipped == LIMIT) begin
      signed_res = LIMIT - 64'd1;
    end else begin
      signed_res = clipped;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      result <= signed_res[OUT_W-1:0];
    end
  end

endmodule

/* hw/rtl/multiturn_angle_tracker.sv */
// ----------------------------------------------------------------------------
// Multi-turn angle tracker
// Turns single-turn motor feedback into saturated output shaft position,
// velocity and torque in Q.16 fixed point.
// ----------------------------------------------------------------------------
// One feedback word is taken per clock while s_tready is high, and one result
// word is returned for each via the sample, tracker, product and result
// registers. The tracker state, updated once per word, sets the rate; the
// scaling is a two-stage multiply pipeline. The user must write settings via
// the cfg port only while no word is in flight; the block does not enforce it.
module multiturn_angle_tracker #(
  parameter int ACCUMULATOR_WIDTH = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // motor_present, online, feedback_ok, rotor_angle, rotor_velocity,
  // iq_current, temperature, zero fill
  input  logic [87:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // online_out, resync, output_position, output_velocity, output_torque,
  // temperature_out, zero fill
  output logic [127:0] m_tdata
);
  import angt_pkg::*;

  localparam int AW = ACCUMULATOR_WIDTH;

  logic [31:0] inverse_gear_ratio;
  logic [31:0] torque_gain;
  logic        output_invert;
  logic [31:0] ratio;

  logic v0, v1, v2, v3;
  logic load0, load1, load2, load3;

  sample_t              sample;
  track_flags_t         flags1, flags2, flags3;
  logic signed [AW-1:0] position1;
  logic signed [27:0]   velocity1;
  logic signed [23:0]   current1;
  logic signed [47:0]   output_position;
  logic signed [31:0]   output_velocity;
  logic signed [31:0]   output_torque;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_gear_ratio <= UNITY_Q16;
      torque_gain        <= '0;
      output_invert      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INVERSE_GEAR_RATIO: inverse_gear_ratio <= cfg_data;
        REG_TORQUE_GAIN:        torque_gain        <= cfg_data;
        REG_OUTPUT_INVERT:      output_invert      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ratio = (inverse_gear_ratio != 32'd0) ? inverse_gear_ratio : UNITY_Q16;

  assign load3    = !v3 || m_tready;
  assign load2    = !v2 || load3;
  assign load1    = !v1 || load2;
  assign load0    = !v0 || load1;
  assign s_tready = load0;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (load0) v0 <= s_tvalid;
      if (load1) v1 <= v0;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (load0) begin
      sample.motor_present  <= s_tdata[0];
      sample.online         <= s_tdata[1];
      sample.feedback_ok    <= s_tdata[2];
      sample.rotor_angle    <= s_tdata[21:3];
      sample.rotor_velocity <= s_tdata[49:22];
      sample.iq_current     <= s_tdata[73:50];
      sample.temperature    <= s_tdata[82:74];
    end
    if (load2) flags2 <= flags1;
    if (load3) flags3 <= flags2;
  end

  angt_tracker #(
    .ACCUMULATOR_WIDTH(AW)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .load     (load1),
    .take     (load1 & v0),
    .sample   (sample),
    .flags    (flags1),
    .position (position1),
    .velocity (velocity1),
    .current  (current1)
  );

  angt_scale #(
    .IN_W (AW),
    .OUT_W(48)
  ) u_scale_position (
    .clk   (clk),
    .en_mul(load2),
    .en_out(load3),
    .value (position1),
    .gain  (ratio),
    .negate(output_invert),
    .result(output_position)
  );

  angt_scale #(
    .IN_W (28),
    .OUT_W(32)
  ) u_scale_velocity (
    .clk   (clk),
    .en_mul(load2),
    .en_out(load3),
    .value (velocity1),
    .gain  (ratio),
    .negate(output_invert),
    .result(output_velocity)
  );

  angt_scale #(
    .IN_W (24),
    .OUT_W(32)
  ) u_scale_torque (
    .clk   (clk),
    .en_mul(load2),
    .en_out(load3),
    .value (current1),
    .gain  (torque_gain),
    .negate(output_invert),
    .result(output_torque)
  );

  assign m_tdata = {5'd0, flags3.temperature_out, output_torque, output_velocity,
                    output_position, flags3.resync, flags3.online_out};

endmodule
